// File: hw/rtl/indent_aware_token_scanner_core_macros.svh
// Assertion macros for the token scanner.
`ifndef INDENT_AWARE_TOKEN_SCANNER_CORE_MACROS_SVH
`define INDENT_AWARE_TOKEN_SCANNER_CORE_MACROS_SVH

// Condition must never hold outside reset.
`define IATS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("never-condition violated");

// Antecedent implies consequent in the same cycle.
`define IATS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication violated");

`endif

// File: hw/rtl/iats_pkg.sv
// ----------------------------------------------------------------------------
// iats_pkg
// Token codes, scan modes, token and bundle types, keyword lookup.
// ----------------------------------------------------------------------------
`default_nettype none
package iats_pkg;

    localparam int MaxRes = 3;

    localparam logic [5:0] K_LPAREN      = 6'd0;
    localparam logic [5:0] K_RPAREN      = 6'd1;
    localparam logic [5:0] K_LBRACE      = 6'd2;
    localparam logic [5:0] K_RBRACE      = 6'd3;
    localparam logic [5:0] K_BEGIN_BLOCK = 6'd4;
    localparam logic [5:0] K_NEWLINE     = 6'd5;
    localparam logic [5:0] K_COMMA       = 6'd6;
    localparam logic [5:0] K_DOT         = 6'd7;
    localparam logic [5:0] K_MINUS       = 6'd8;
    localparam logic [5:0] K_PLUS        = 6'd9;
    localparam logic [5:0] K_SLASH       = 6'd10;
    localparam logic [5:0] K_STAR        = 6'd11;
    localparam logic [5:0] K_PERCENT     = 6'd12;
    localparam logic [5:0] K_CARET       = 6'd13;
    localparam logic [5:0] K_BANG        = 6'd14;
    localparam logic [5:0] K_EQUAL       = 6'd16;
    localparam logic [5:0] K_LESS        = 6'd18;
    localparam logic [5:0] K_GREATER     = 6'd20;
    localparam logic [5:0] K_IDENT       = 6'd22;
    localparam logic [5:0] K_STRING      = 6'd23;
    localparam logic [5:0] K_NUMBER      = 6'd24;
    localparam logic [5:0] K_AND         = 6'd25;
    localparam logic [5:0] K_CLASS       = 6'd26;
    localparam logic [5:0] K_DEF         = 6'd27;
    localparam logic [5:0] K_ELSE        = 6'd28;
    localparam logic [5:0] K_FALSE       = 6'd29;
    localparam logic [5:0] K_FOR         = 6'd30;
    localparam logic [5:0] K_IF          = 6'd31;
    localparam logic [5:0] K_NIL         = 6'd32;
    localparam logic [5:0] K_OR          = 6'd33;
    localparam logic [5:0] K_PRINT       = 6'd34;
    localparam logic [5:0] K_RETURN      = 6'd35;
    localparam logic [5:0] K_SUPER       = 6'd36;
    localparam logic [5:0] K_THIS        = 6'd37;
    localparam logic [5:0] K_TRUE        = 6'd38;
    localparam logic [5:0] K_VAR         = 6'd39;
    localparam logic [5:0] K_WHILE       = 6'd40;
    localparam logic [5:0] K_UNINDENT    = 6'd41;
    localparam logic [5:0] K_EOF         = 6'd42;
    localparam logic [5:0] K_ERR_STRING  = 6'd43;
    localparam logic [5:0] K_ERR_CHAR    = 6'd44;

    typedef enum logic [11:0] {
        M_IDLE         = 12'b0000_0000_0001,
        M_IDENT        = 12'b0000_0000_0010,
        M_NUMBER       = 12'b0000_0000_0100,
        M_NUM_DOT      = 12'b0000_0000_1000,
        M_NUM_FRAC     = 12'b0000_0001_0000,
        M_STRING       = 12'b0000_0010_0000,
        M_HELD         = 12'b0000_0100_0000,
        M_LINE_COMMENT = 12'b0000_1000_0000,
        M_BLOCK        = 12'b0001_0000_0000,
        M_BLOCK_STAR   = 12'b0010_0000_0000,
        M_TABS         = 12'b0100_0000_0000,
        M_DONE         = 12'b1000_0000_0000
    } t_mode;

    typedef struct packed {
        logic [5:0]  kind;
        logic [19:0] off;
        logic [19:0] len;
        logic [15:0] line;
    } t_token;

    // last holds the token count minus one
    typedef struct packed {
        logic [1:0]               last;
        t_token [MaxRes-1:0]      tok;
    } t_bundle;

    // w holds the first six identifier bytes, first byte in the top bits
    function automatic logic [5:0] kw_kind(input logic [3:0] len, input logic [47:0] w);
        logic [5:0] k;
        k = K_IDENT;
        case (len)
            4'd2: begin
                if (w[47:32] == "if") k = K_IF;
                else if (w[47:32] == "or") k = K_OR;
            end
            4'd3: begin
                if (w[47:24] == "and") k = K_AND;
                else if (w[47:24] == "def") k = K_DEF;
                else if (w[47:24] == "for") k = K_FOR;
                else if (w[47:24] == "nil") k = K_NIL;
                else if (w[47:24] == "var") k = K_VAR;
            end
            4'd4: begin
                if (w[47:16] == "else") k = K_ELSE;
                else if (w[47:16] == "this") k = K_THIS;
                else if (w[47:16] == "true") k = K_TRUE;
            end
            4'd5: begin
                if (w[47:8] == "class") k = K_CLASS;
                else if (w[47:8] == "false") k = K_FALSE;
                else if (w[47:8] == "print") k = K_PRINT;
                else if (w[47:8] == "super") k = K_SUPER;
                else if (w[47:8] == "while") k = K_WHILE;
            end
            4'd6: begin
                if (w == "return") k = K_RETURN;
            end
            default: k = K_IDENT;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/iats_if.sv
// ----------------------------------------------------------------------------
// iats_if
// Valid/ready channels for source bytes and tokens.
// ----------------------------------------------------------------------------
`default_nettype none
interface iats_src_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;
    logic       end_of_source;
    modport source (output valid, source_byte, end_of_source, input ready);
    modport sink   (input valid, source_byte, end_of_source, output ready);
endinterface

interface iats_tok_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic [19:0] start_offset;
    logic [19:0] token_length;
    logic [15:0] line_number;
    logic        last_of_run;
    modport source (output valid, token_kind, start_offset, token_length, line_number,
                    last_of_run, input ready);
    modport sink   (input valid, token_kind, start_offset, token_length, line_number,
                    last_of_run, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/iats_front.sv
// ----------------------------------------------------------------------------
// iats_front
// Scan one byte a cycle while the back has space, update lexer state, build the token bundle.
// ----------------------------------------------------------------------------
`default_nettype none
module iats_front #(
    parameter int POS_WIDTH     = 20,
    parameter int LINE_WIDTH    = 16,
    parameter int MAX_INDENT    = 15,
    parameter int KEYWORD_CHARS = 6
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    iats_src_if.sink        i_src,
    input  wire logic       i_space,
    output logic            o_push,
    output iats_pkg::t_bundle o_bundle
);
    localparam int IW = $clog2(MAX_INDENT + 1);
    localparam logic [7:0] C_TAB = 8'h09, C_NL = 8'h0A, C_CR = 8'h0D, C_SP = 8'h20;

    iats_pkg::t_mode r_mode, n_mode;
    logic [POS_WIDTH-1:0]  r_pos, n_pos, r_begin, n_begin;
    logic [LINE_WIDTH-1:0] r_line, n_line;
    logic [7:0]            r_kw [KEYWORD_CHARS];
    logic [7:0]            n_kw [KEYWORD_CHARS];
    logic [7:0]            r_held, n_held;
    logic [IW-1:0]         r_depth, n_depth, r_tabs, n_tabs;
    logic                  r_track, n_track;

    iats_pkg::t_token      tk [iats_pkg::MaxRes];
    logic [1:0]            cnt;
    logic                  acc;

    function automatic logic [19:0] sat_off(input logic [POS_WIDTH-1:0] v);
        logic [32:0] x;
        x = 33'(v);
        return (x > 33'hFFFFF) ? 20'hFFFFF : x[19:0];
    endfunction

    function automatic logic [15:0] sat_line(input logic [LINE_WIDTH-1:0] v);
        logic [32:0] x;
        x = 33'(v);
        return (x > 33'hFFFF) ? 16'hFFFF : x[15:0];
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [5:0] held_single(input logic [7:0] h);
        case (h)
            "!":     return iats_pkg::K_BANG;
            "=":     return iats_pkg::K_EQUAL;
            "<":     return iats_pkg::K_LESS;
            ">":     return iats_pkg::K_GREATER;
            default: return iats_pkg::K_SLASH;
        endcase
    endfunction

    assign i_src.ready = i_space;
    assign acc = i_src.valid && i_space;

    always_comb begin
        logic [7:0]           c;
        logic                 ends, do_start;
        logic [POS_WIDTH-1:0] dot, sp, ln;
        logic [47:0]          w;
        logic [3:0]           kl;
        logic [5:0]           kk;
        c = i_src.source_byte;
        ends = i_src.end_of_source || c == 8'd0;
        do_start = 1'b0;
        n_mode = r_mode; n_pos = r_pos; n_begin = r_begin; n_line = r_line;
        n_kw = r_kw; n_held = r_held; n_depth = r_depth; n_tabs = r_tabs;
        n_track = r_track;
        cnt = 2'd0;
        for (int i = 0; i < iats_pkg::MaxRes; i++) tk[i] = '0;
        dot = (r_pos != '0) ? r_pos - 1'b1 : '0;
        sp = (r_pos >= r_begin) ? r_pos - r_begin : '0;
        ln = (dot >= r_begin) ? dot - r_begin : '0;
        w = {r_kw[0], r_kw[1], r_kw[2], r_kw[3], r_kw[4], r_kw[5]};
        kl = (sp <= POS_WIDTH'(6)) ? sp[3:0] : 4'd0;
        kk = iats_pkg::kw_kind(kl, w);

        if (r_mode == iats_pkg::M_DONE) begin
            tk[cnt] = '{iats_pkg::K_EOF, sat_off(r_pos), 20'd0, sat_line(r_line)};
            cnt = cnt + 2'd1;
        end else if (ends) begin
            unique case (r_mode)
                iats_pkg::M_IDENT: begin
                    tk[cnt] = '{kk, sat_off(r_begin), sat_off(sp), sat_line(r_line)};
                    cnt = cnt + 2'd1;
                end
                iats_pkg::M_NUMBER, iats_pkg::M_NUM_FRAC: begin
                    tk[cnt] = '{iats_pkg::K_NUMBER, sat_off(r_begin), sat_off(sp),
                                sat_line(r_line)};
                    cnt = cnt + 2'd1;
                end
                iats_pkg::M_NUM_DOT: begin
                    tk[cnt] = '{iats_pkg::K_NUMBER, sat_off(r_begin), sat_off(ln),
                                sat_line(r_line)};
                    cnt = cnt + 2'd1;
                    tk[cnt] = '{iats_pkg::K_DOT, sat_off(dot), 20'd1, sat_line(r_line)};
                    cnt = cnt + 2'd1;
                end
                iats_pkg::M_STRING: begin
                    tk[cnt] = '{iats_pkg::K_ERR_STRING, sat_off(r_begin), 20'd0,
                                sat_line(r_line)};
                    cnt = cnt + 2'd1;
                end
                iats_pkg::M_HELD: begin
                    tk[cnt] = '{held_single(r_held), sat_off(r_begin), 20'd1,
                                sat_line(r_line)};
                    cnt = cnt + 2'd1;
                end
                iats_pkg::M_TABS: begin
                    tk[cnt] = '{iats_pkg::K_NEWLINE, sat_off(r_begin), sat_off(sp),
                                sat_line(r_line)};
                    cnt = cnt + 2'd1;
                    if (r_tabs < r_depth) begin
                        tk[cnt] = '{iats_pkg::K_UNINDENT, sat_off(r_pos), 20'd0,
                                    sat_line(r_line)};
                        cnt = cnt + 2'd1;
                        n_depth = r_depth - 1'b1;
                    end
                    if (n_depth == '0) n_track = 1'b0;
                end
                default: ;
            endcase
            tk[cnt] = '{iats_pkg::K_EOF, sat_off(r_pos), 20'd0, sat_line(r_line)};
            cnt = cnt + 2'd1;
            n_mode = iats_pkg::M_DONE;
        end else begin
            unique case (r_mode)
                iats_pkg::M_IDENT: begin
                    if (is_alpha(c) || is_digit(c)) begin
                        for (int i = 0; i < KEYWORD_CHARS; i++)
                            if (sp == POS_WIDTH'(i)) n_kw[i] = c;
                    end else begin
                        tk[cnt] = '{kk, sat_off(r_begin), sat_off(sp), sat_line(r_line)};
                        cnt = cnt + 2'd1;
                        do_start = 1'b1;
                    end
                end
                iats_pkg::M_NUMBER: begin
                    if (c == ".") n_mode = iats_pkg::M_NUM_DOT;
                    else if (!is_digit(c)) begin
                        tk[cnt] = '{iats_pkg::K_NUMBER, sat_off(r_begin), sat_off(sp),
                                    sat_line(r_line)};
                        cnt = cnt + 2'd1;
                        do_start = 1'b1;
                    end
                end
                iats_pkg::M_NUM_DOT: begin
                    if (is_digit(c)) n_mode = iats_pkg::M_NUM_FRAC;
                    else begin
                        tk[cnt] = '{iats_pkg::K_NUMBER, sat_off(r_begin), sat_off(ln),
                                    sat_line(r_line)};
                        cnt = cnt + 2'd1;
                        tk[cnt] = '{iats_pkg::K_DOT, sat_off(dot), 20'd1, sat_line(r_line)};
                        cnt = cnt + 2'd1;
                        do_start = 1'b1;
                    end
                end
                iats_pkg::M_NUM_FRAC: begin
                    if (!is_digit(c)) begin
                        tk[cnt] = '{iats_pkg::K_NUMBER, sat_off(r_begin), sat_off(sp),
                                    sat_line(r_line)};
                        cnt = cnt + 2'd1;
                        do_start = 1'b1;
                    end
                end
                iats_pkg::M_STRING: begin
                    if (c == "\"") begin
                        // hold the length at its maximum instead of wrapping
                        tk[cnt] = '{iats_pkg::K_STRING, sat_off(r_begin),
                                    (sp == '1) ? 20'hFFFFF : sat_off(sp + 1'b1),
                                    sat_line(r_line)};
                        cnt = cnt + 2'd1;
                        n_mode = iats_pkg::M_IDLE;
                    end else if (c == C_NL && r_line != '1) n_line = r_line + 1'b1;
                end
                iats_pkg::M_HELD: begin
                    if (r_held == "/" && c == "*") n_mode = iats_pkg::M_BLOCK;
                    else if (r_held != "/" && c == "=") begin
                        tk[cnt] = '{held_single(r_held) + 6'd1, sat_off(r_begin), 20'd2,
                                    sat_line(r_line)};
                        cnt = cnt + 2'd1;
                        n_mode = iats_pkg::M_IDLE;
                    end else begin
                        tk[cnt] = '{held_single(r_held), sat_off(r_begin), 20'd1,
                                    sat_line(r_line)};
                        cnt = cnt + 2'd1;
                        do_start = 1'b1;
                    end
                end
                iats_pkg::M_LINE_COMMENT: begin
                    if (c == C_NL) do_start = 1'b1;
                end
                iats_pkg::M_BLOCK: begin
                    if (c == "*") n_mode = iats_pkg::M_BLOCK_STAR;
                    else if (c == C_NL && r_line != '1) n_line = r_line + 1'b1;
                end
                iats_pkg::M_BLOCK_STAR: begin
                    if (c == "/") n_mode = iats_pkg::M_IDLE;
                    else if (c != "*") begin
                        if (c == C_NL && r_line != '1) n_line = r_line + 1'b1;
                        n_mode = iats_pkg::M_BLOCK;
                    end
                end
                iats_pkg::M_TABS: begin
                    if (c == C_TAB) begin
                        if (r_tabs < IW'(MAX_INDENT)) n_tabs = r_tabs + 1'b1;
                    end else begin
                        tk[cnt] = '{iats_pkg::K_NEWLINE, sat_off(r_begin), sat_off(sp),
                                    sat_line(r_line)};
                        cnt = cnt + 2'd1;
                        if (r_tabs < r_depth) begin
                            tk[cnt] = '{iats_pkg::K_UNINDENT, sat_off(r_pos), 20'd0,
                                        sat_line(r_line)};
                            cnt = cnt + 2'd1;
                            n_depth = r_depth - 1'b1;
                        end
                        if (n_depth == '0) n_track = 1'b0;
                        do_start = 1'b1;
                    end
                end
                default: do_start = 1'b1;
            endcase

            // open a new token on this byte
            if (do_start) begin
                n_mode = iats_pkg::M_IDLE;
                if (is_alpha(c)) begin
                    n_begin = r_pos; n_kw[0] = c; n_mode = iats_pkg::M_IDENT;
                end else if (is_digit(c)) begin
                    n_begin = r_pos; n_mode = iats_pkg::M_NUMBER;
                end else begin
                    case (c)
                        C_SP, C_CR: ;
                        "#": n_mode = iats_pkg::M_LINE_COMMENT;
                        "\"": begin
                            n_begin = r_pos; n_mode = iats_pkg::M_STRING;
                        end
                        "!", "=", "<", ">", "/": begin
                            n_begin = r_pos; n_held = c; n_mode = iats_pkg::M_HELD;
                        end
                        C_NL: begin
                            if (n_line != '1) n_line = n_line + 1'b1;
                            n_begin = r_pos;
                            if (n_track) begin
                                n_tabs = '0; n_mode = iats_pkg::M_TABS;
                            end else begin
                                tk[cnt] = '{iats_pkg::K_NEWLINE, sat_off(r_pos), 20'd1,
                                            sat_line(n_line)};
                                cnt = cnt + 2'd1;
                            end
                        end
                        ":": begin
                            if (n_depth < IW'(MAX_INDENT)) n_depth = n_depth + 1'b1;
                            n_track = 1'b1;
                            tk[cnt] = '{iats_pkg::K_BEGIN_BLOCK, sat_off(r_pos), 20'd1,
                                        sat_line(n_line)};
                            cnt = cnt + 2'd1;
                        end
                        default: begin
                            case (c)
                                "(": kk = iats_pkg::K_LPAREN;
                                ")": kk = iats_pkg::K_RPAREN;
                                "{": kk = iats_pkg::K_LBRACE;
                                "}": kk = iats_pkg::K_RBRACE;
                                ",": kk = iats_pkg::K_COMMA;
                                ".": kk = iats_pkg::K_DOT;
                                "-": kk = iats_pkg::K_MINUS;
                                "+": kk = iats_pkg::K_PLUS;
                                "*": kk = iats_pkg::K_STAR;
                                "%": kk = iats_pkg::K_PERCENT;
                                "^": kk = iats_pkg::K_CARET;
                                default: kk = iats_pkg::K_ERR_CHAR;
                            endcase
                            tk[cnt] = '{kk, sat_off(r_pos),
                                        (kk == iats_pkg::K_ERR_CHAR) ? 20'd0 : 20'd1,
                                        sat_line(n_line)};
                            cnt = cnt + 2'd1;
                        end
                    endcase
                end
            end
            if (r_pos != '1) n_pos = r_pos + 1'b1;
        end
    end

    assign o_push = acc && cnt != 2'd0;
    always_comb begin
        o_bundle.last = cnt - 2'd1;
        for (int i = 0; i < iats_pkg::MaxRes; i++) o_bundle.tok[i] = tk[i];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= iats_pkg::M_IDLE;
            r_pos <= '0; r_begin <= '0; r_line <= LINE_WIDTH'(1);
            r_held <= '0; r_depth <= '0; r_tabs <= '0; r_track <= 1'b0;
        end else if (acc) begin
            r_mode <= n_mode; r_pos <= n_pos; r_begin <= n_begin; r_line <= n_line;
            r_held <= n_held; r_depth <= n_depth; r_tabs <= n_tabs; r_track <= n_track;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) r_kw <= n_kw;
    end
endmodule
`default_nettype wire

// File: hw/rtl/iats_back.sv
// ----------------------------------------------------------------------------
// iats_back
// Bundle queue and token serializer with a registered output.
// ----------------------------------------------------------------------------
`default_nettype none
`include "indent_aware_token_scanner_core_macros.svh"
module iats_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  iats_pkg::t_bundle  i_bundle,
    output logic               o_space,
    iats_tok_if.source         o_tok
);
    iats_pkg::t_bundle r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt, r_idx;
    logic       r_ov, r_olast;
    iats_pkg::t_token r_otok;
    iats_pkg::t_bundle head;
    logic load, pop;

    assign o_space = r_cnt != 2'd2;
    assign head = r_q[r_rp];
    assign load = r_cnt != 2'd0 && (!r_ov || o_tok.ready);
    assign pop = load && r_idx == head.last;

    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wp] <= i_bundle;
        if (load) begin
            r_otok <= head.tok[r_idx];
            r_olast <= pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0; r_idx <= '0; r_ov <= 1'b0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, pop};
            // advance within the head bundle, restart on pop
            if (pop) r_idx <= '0;
            else if (load) r_idx <= r_idx + 2'd1;
            if (load) r_ov <= 1'b1;
            else if (o_tok.ready) r_ov <= 1'b0;
        end
    end

    assign o_tok.valid = r_ov;
    assign o_tok.token_kind = r_otok.kind;
    assign o_tok.start_offset = r_otok.off;
    assign o_tok.token_length = r_otok.len;
    assign o_tok.line_number = r_otok.line;
    assign o_tok.last_of_run = r_olast;

    `IATS_ASSERT_NEVER(a_cnt_range, i_clk, i_rst_n, r_cnt == 2'd3)
    `IATS_ASSERT_IMPLY(a_no_overflow, i_clk, i_rst_n, i_push, r_cnt != 2'd2 || pop)
    `IATS_ASSERT_IMPLY(a_idx_in_bundle, i_clk, i_rst_n, r_cnt != 2'd0, r_idx <= head.last)
endmodule
`default_nettype wire

// File: hw/rtl/indent_aware_token_scanner_core.sv
// ----------------------------------------------------------------------------
// indent_aware_token_scanner_core
// Streaming lexer: source bytes in, tokens with offset, length and line out.
// ----------------------------------------------------------------------------
//  port    dir  payload                                                 item
//  i_src   in   source_byte, end_of_source                              byte
//  o_tok   out  token_kind, start_offset, token_length, line_number,    token
//               last_of_run
//
// One byte is accepted per cycle while the bundle queue has room; the front
// updates all lexer state in that cycle and queues the tokens the byte releases.
// The back sends one token per cycle while the receiver is ready, draining each
// bundle in order; the two-entry queue absorbs short bursts.
// Reset is synchronous, active low; the keyword byte buffer is not reset.
// Output stalls hold the output register and back-pressure through the queue.
// ----------------------------------------------------------------------------
`default_nettype none
module indent_aware_token_scanner_core #(
    parameter int POS_WIDTH     = 20,
    parameter int LINE_WIDTH    = 16,
    parameter int MAX_INDENT    = 15,
    parameter int KEYWORD_CHARS = 6
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    iats_src_if.sink   i_src,
    iats_tok_if.source o_tok
);
    logic              push, space;
    iats_pkg::t_bundle bundle;

    // front: classify each byte and build its token bundle
    iats_front #(
        .POS_WIDTH(POS_WIDTH), .LINE_WIDTH(LINE_WIDTH),
        .MAX_INDENT(MAX_INDENT), .KEYWORD_CHARS(KEYWORD_CHARS)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_src(i_src),
        .i_space(space), .o_push(push), .o_bundle(bundle)
    );

    // back: queue bundles, drain one token per cycle while the receiver is ready
    iats_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_bundle(bundle),
        .o_space(space), .o_tok(o_tok)
    );
endmodule
`default_nettype wire

// File: sim/token_scoreboard.sv
// ----------------------------------------------------------------------------
// token_scoreboard
// Watches the byte and token channels, predicts the tokens of every accepted
// byte from its own copy of the lexer state, and compares them in order.
// ----------------------------------------------------------------------------
`default_nettype none
module token_scoreboard (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    iats_src_if       src,
    iats_tok_if       tok,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_checked
);

    typedef struct {
        logic [5:0]  kind;
        logic [19:0] off;
        logic [19:0] len;
        logic [15:0] line;
        logic        last;
    } t_exp_token;

    localparam int MaxTokens = 4;
    localparam int KwChars   = 6;
    localparam int MaxDepth  = 15;

    t_exp_token  expected_tokens[$];
    int          run_count;

    iats_pkg::t_mode mode;
    logic [19:0] byte_pos;
    logic [19:0] tok_begin;
    logic [15:0] line_ctr;
    logic [7:0]  kw_buf[KwChars];
    logic [7:0]  held_op;
    logic [3:0]  depth;
    logic        tracking;
    logic [3:0]  tab_count;

    string       kw_text[16] = '{"and", "class", "def", "else", "false", "for", "if",
                                 "nil", "or", "print", "return", "super", "this",
                                 "true", "var", "while"};
    logic [5:0]  kw_code[16] = '{iats_pkg::K_AND, iats_pkg::K_CLASS, iats_pkg::K_DEF,
                                 iats_pkg::K_ELSE, iats_pkg::K_FALSE, iats_pkg::K_FOR,
                                 iats_pkg::K_IF, iats_pkg::K_NIL, iats_pkg::K_OR,
                                 iats_pkg::K_PRINT, iats_pkg::K_RETURN, iats_pkg::K_SUPER,
                                 iats_pkg::K_THIS, iats_pkg::K_TRUE, iats_pkg::K_VAR,
                                 iats_pkg::K_WHILE};

    assign o_pending = expected_tokens.size();

    function automatic void emit(logic [5:0] kind, logic [19:0] off, logic [19:0] len);
        t_exp_token t;
        if (run_count >= MaxTokens) return;
        t.kind = kind;
        t.off  = off;
        t.len  = len;
        t.line = line_ctr;
        t.last = 1'b0;
        expected_tokens.push_back(t);
        run_count++;
    endfunction

    function automatic logic [19:0] span(logic [19:0] e);
        return (e >= tok_begin) ? e - tok_begin : 20'd0;
    endfunction

    function automatic void bump_line();
        if (line_ctr != 16'hFFFF) line_ctr++;
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void finish_ident(logic [19:0] e);
        logic [19:0] len;
        logic [5:0]  kind;
        bit          hit;
        len  = span(e);
        kind = iats_pkg::K_IDENT;
        for (int i = 0; i < 16; i++) begin
            if (len == kw_text[i].len() && len <= KwChars && kind == iats_pkg::K_IDENT) begin
                hit = 1;
                for (int j = 0; j < kw_text[i].len(); j++)
                    if (kw_buf[j] != kw_text[i][j]) hit = 0;
                if (hit) kind = kw_code[i];
            end
        end
        emit(kind, tok_begin, len);
    endfunction

    function automatic logic [5:0] held_kind();
        case (held_op)
            "!":     return iats_pkg::K_BANG;
            "=":     return iats_pkg::K_EQUAL;
            "<":     return iats_pkg::K_LESS;
            ">":     return iats_pkg::K_GREATER;
            default: return iats_pkg::K_SLASH;
        endcase
    endfunction

    function automatic void finish_newline(logic [19:0] e);
        emit(iats_pkg::K_NEWLINE, tok_begin, span(e));
        if (tab_count < depth) begin
            emit(iats_pkg::K_UNINDENT, e, 20'd0);
            depth--;
        end
        if (depth == 0) tracking = 1'b0;
    endfunction

    function automatic void start_byte(logic [7:0] c, logic [19:0] p);
        mode = iats_pkg::M_IDLE;
        if (is_alpha(c)) begin
            tok_begin = p;
            kw_buf[0] = c;
            mode = iats_pkg::M_IDENT;
        end else if (is_digit(c)) begin
            tok_begin = p;
            mode = iats_pkg::M_NUMBER;
        end else begin
            case (c)
                " ", "\r": ;
                "#": mode = iats_pkg::M_LINE_COMMENT;
                "\"": begin
                    tok_begin = p;
                    mode = iats_pkg::M_STRING;
                end
                "!", "=", "<", ">", "/": begin
                    tok_begin = p;
                    held_op = c;
                    mode = iats_pkg::M_HELD;
                end
                "\n": begin
                    bump_line();
                    tok_begin = p;
                    if (tracking) begin
                        tab_count = 0;
                        mode = iats_pkg::M_TABS;
                    end else begin
                        emit(iats_pkg::K_NEWLINE, p, 20'd1);
                    end
                end
                ":": begin
                    if (depth < MaxDepth) depth++;
                    tracking = 1'b1;
                    emit(iats_pkg::K_BEGIN_BLOCK, p, 20'd1);
                end
                "(":     emit(iats_pkg::K_LPAREN, p, 20'd1);
                ")":     emit(iats_pkg::K_RPAREN, p, 20'd1);
                "{":     emit(iats_pkg::K_LBRACE, p, 20'd1);
                "}":     emit(iats_pkg::K_RBRACE, p, 20'd1);
                ",":     emit(iats_pkg::K_COMMA, p, 20'd1);
                ".":     emit(iats_pkg::K_DOT, p, 20'd1);
                "-":     emit(iats_pkg::K_MINUS, p, 20'd1);
                "+":     emit(iats_pkg::K_PLUS, p, 20'd1);
                "*":     emit(iats_pkg::K_STAR, p, 20'd1);
                "%":     emit(iats_pkg::K_PERCENT, p, 20'd1);
                "^":     emit(iats_pkg::K_CARET, p, 20'd1);
                default: emit(iats_pkg::K_ERR_CHAR, p, 20'd0);
            endcase
        end
    endfunction

    function automatic void flush_text(logic [19:0] p);
        logic [19:0] dot;
        dot = (p > 20'd0) ? p - 20'd1 : 20'd0;
        case (mode)
            iats_pkg::M_IDENT: finish_ident(p);
            iats_pkg::M_NUMBER, iats_pkg::M_NUM_FRAC:
                emit(iats_pkg::K_NUMBER, tok_begin, span(p));
            iats_pkg::M_NUM_DOT: begin
                emit(iats_pkg::K_NUMBER, tok_begin, span(dot));
                emit(iats_pkg::K_DOT, dot, 20'd1);
            end
            iats_pkg::M_STRING: emit(iats_pkg::K_ERR_STRING, tok_begin, 20'd0);
            iats_pkg::M_HELD:   emit(held_kind(), tok_begin, 20'd1);
            iats_pkg::M_TABS:   finish_newline(p);
            default: ;
        endcase
        emit(iats_pkg::K_EOF, p, 20'd0);
        mode = iats_pkg::M_DONE;
    endfunction

    function automatic void take_byte(logic [7:0] c, logic [19:0] p);
        logic [19:0] dot;
        logic [19:0] idx;
        logic [19:0] slen;
        dot = (p > 20'd0) ? p - 20'd1 : 20'd0;
        case (mode)
            iats_pkg::M_IDENT: begin
                if (is_alpha(c) || is_digit(c)) begin
                    idx = span(p);
                    if (idx < KwChars) kw_buf[idx] = c;
                end else begin
                    finish_ident(p);
                    start_byte(c, p);
                end
            end
            iats_pkg::M_NUMBER: begin
                if (c == ".") mode = iats_pkg::M_NUM_DOT;
                else if (!is_digit(c)) begin
                    emit(iats_pkg::K_NUMBER, tok_begin, span(p));
                    start_byte(c, p);
                end
            end
            iats_pkg::M_NUM_DOT: begin
                if (is_digit(c)) mode = iats_pkg::M_NUM_FRAC;
                else begin
                    emit(iats_pkg::K_NUMBER, tok_begin, span(dot));
                    emit(iats_pkg::K_DOT, dot, 20'd1);
                    start_byte(c, p);
                end
            end
            iats_pkg::M_NUM_FRAC: begin
                if (!is_digit(c)) begin
                    emit(iats_pkg::K_NUMBER, tok_begin, span(p));
                    start_byte(c, p);
                end
            end
            iats_pkg::M_STRING: begin
                if (c == "\"") begin
                    slen = (span(p) == 20'hFFFFF) ? 20'hFFFFF : span(p) + 20'd1;
                    emit(iats_pkg::K_STRING, tok_begin, slen);
                    mode = iats_pkg::M_IDLE;
                end else if (c == "\n") begin
                    bump_line();
                end
            end
            iats_pkg::M_HELD: begin
                if (held_op == "/" && c == "*") mode = iats_pkg::M_BLOCK;
                else if (held_op != "/" && c == "=") begin
                    emit(held_kind() + 6'd1, tok_begin, 20'd2);
                    mode = iats_pkg::M_IDLE;
                end else begin
                    emit(held_kind(), tok_begin, 20'd1);
                    start_byte(c, p);
                end
            end
            iats_pkg::M_LINE_COMMENT: if (c == "\n") start_byte(c, p);
            iats_pkg::M_BLOCK: begin
                if (c == "*") mode = iats_pkg::M_BLOCK_STAR;
                else if (c == "\n") bump_line();
            end
            iats_pkg::M_BLOCK_STAR: begin
                if (c == "/") mode = iats_pkg::M_IDLE;
                else if (c != "*") begin
                    if (c == "\n") bump_line();
                    mode = iats_pkg::M_BLOCK;
                end
            end
            iats_pkg::M_TABS: begin
                if (c == "\t") begin
                    if (tab_count < MaxDepth) tab_count++;
                end else begin
                    finish_newline(p);
                    start_byte(c, p);
                end
            end
            default: start_byte(c, p);
        endcase
    endfunction

    function automatic void scan_item(logic [7:0] c, logic eos);
        run_count = 0;
        if (mode == iats_pkg::M_DONE) emit(iats_pkg::K_EOF, byte_pos, 20'd0);
        else if (eos || c == 8'd0) flush_text(byte_pos);
        else begin
            take_byte(c, byte_pos);
            if (byte_pos != 20'hFFFFF) byte_pos++;
        end
        if (run_count > 0) expected_tokens[expected_tokens.size() - 1].last = 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_exp_token want;
        if (!i_rst_n) begin
            mode      = iats_pkg::M_IDLE;
            byte_pos  = 0;
            tok_begin = 0;
            line_ctr  = 16'd1;
            held_op   = 0;
            depth     = 0;
            tracking  = 0;
            tab_count = 0;
            expected_tokens.delete();
            o_fail_count = 0;
            o_checked    = 0;
        end else begin
            if (src.valid && src.ready) scan_item(src.source_byte, src.end_of_source);
            if (tok.valid && tok.ready) begin
                o_checked++;
                if (expected_tokens.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("ERROR: unexpected token kind %0d off %0d", tok.token_kind,
                                 tok.start_offset);
                end else begin
                    want = expected_tokens.pop_front();
                    if (tok.token_kind !== want.kind || tok.start_offset !== want.off ||
                        tok.token_length !== want.len || tok.line_number !== want.line ||
                        tok.last_of_run !== want.last) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $write("ERROR: token exp k%0d o%0d l%0d ln%0d e%0d",
                                   want.kind, want.off, want.len, want.line, want.last);
                            $display(" got k%0d o%0d l%0d ln%0d e%0d",
                                     tok.token_kind, tok.start_offset, tok.token_length,
                                     tok.line_number, tok.last_of_run);
                        end
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Feeds source text to the token scanner: a directed program with all operators,
// then random well-formed snippets mixed with stray bytes, then one end of text
// and a few items after it. Both channels idle at random in phases.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;

    logic i_clk = 1'b0;
    logic i_rst_n;

    iats_src_if src ();
    iats_tok_if tok ();

    int fail_count;
    int pending;
    int checked;

    // stimulus program: byte plus end-of-text flag
    logic [8:0] text_items[$];

    int  tx_idle;
    int  rx_idle;
    bit  hold_req;
    int  sent;

    always #2 i_clk = ~i_clk;

    indent_aware_token_scanner_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_src   (src.sink),
        .o_tok   (tok.source)
    );

    token_scoreboard scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .src          (src),
        .tok          (tok),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // append a string of source text
    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) text_items.push_back({1'b0, s[i]});
    endtask

    task automatic add_byte(logic [7:0] b);
        text_items.push_back({1'b0, b});
    endtask

    // random letters, digits and underscores, first one a letter or underscore
    task automatic add_word(int n);
        string alnum;
        alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
        add_byte(alnum[$urandom_range(0, 52)]);
        for (int i = 1; i < n; i++) add_byte(alnum[$urandom_range(0, 62)]);
    endtask

    task automatic add_digits(int n);
        for (int i = 0; i < n; i++) add_byte(8'("0" + $urandom_range(0, 9)));
    endtask

    // one random snippet; most are well formed
    task automatic add_snippet();
        string kws[16];
        string ops;
        kws = '{"and", "class", "def", "else", "false", "for", "if", "nil", "or",
                "print", "return", "super", "this", "true", "var", "while"};
        ops = "(){},.-+*%^!=<>/";
        case ($urandom_range(0, 12))
            0, 1: begin
                add_text(kws[$urandom_range(0, 15)]);
                add_byte(" ");
            end
            2: begin
                add_word($urandom_range(1, 9));
                add_byte(" ");
            end
            3: add_digits($urandom_range(1, 4));
            4: begin
                add_digits($urandom_range(1, 3));
                add_byte(".");
                if ($urandom_range(0, 2) != 0) add_digits($urandom_range(1, 3));
            end
            5: begin
                add_byte("\"");
                add_word($urandom_range(1, 4));
                if ($urandom_range(0, 3) == 0) add_byte("\n");
                add_byte("\"");
            end
            6, 7: begin
                add_byte(ops[$urandom_range(0, 15)]);
                if ($urandom_range(0, 2) == 0) add_byte("=");
            end
            8: begin
                add_text("# ");
                add_word($urandom_range(1, 4));
                add_byte("\n");
            end
            9: begin
                add_text("/*");
                add_word($urandom_range(0, 3) + 1);
                if ($urandom_range(0, 1)) add_text("*\n*");
                add_text("*/");
            end
            10: begin
                if ($urandom_range(0, 1)) add_byte(":");
                add_byte("\n");
                repeat ($urandom_range(0, 3)) add_byte("\t");
            end
            11: add_byte(" ");
            default: add_byte(8'($urandom_range(1, 255)));
        endcase
    endtask

    task automatic build_program();
        int base;
        // directed: operators, numbers, nested blocks, strings, comments, errors
        add_text("var x1 = 3.14 + 2. * (y) != z <= >= == ! = < > / -,%^{}:\n\tif a:\n\t\tb\n");
        add_text("\tc\n\"s\nt\" #c\n/* a\n** / */ return class @\t while\n");
        add_byte(8'hFF);
        add_byte(8'h80);
        base = text_items.size();
        while (text_items.size() < base + 185) add_snippet();
        // the one end of text: leave a token or a construct open at random
        case ($urandom_range(0, 4))
            0: add_text("\"open");
            1: add_text("12.");
            2: add_text("/* open");
            3: add_text("name");
            default: add_text(":\n\t");
        endcase
        text_items.push_back({1'b1, 8'($urandom_range(0, 255))});
        text_items.push_back({1'b0, 8'd0});
        text_items.push_back({1'b0, 8'($urandom_range(1, 255))});
        text_items.push_back({1'b1, 8'hFF});
    endtask

    // receiver: random stalls plus one long hold-off
    initial begin
        tok.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                tok.ready <= 1'b0;
                repeat (80) @(posedge i_clk);
            end
            tok.ready <= ($urandom_range(0, 99) >= rx_idle);
        end
    end

    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int n;
        int drain;
        src.valid         <= 1'b0;
        src.source_byte   <= 8'd0;
        src.end_of_source <= 1'b0;
        i_rst_n           <= 1'b0;
        tx_idle  = 12;
        rx_idle  = 53;
        hold_req = 1'b0;
        sent     = 0;
        build_program();
        n = text_items.size();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int i = 0; i < n; i++) begin
            // switch idling phase by position in the program
            if (i == n / 3) begin
                tx_idle = 53;
                rx_idle = 12;
            end
            if (i == 2 * n / 3) begin
                tx_idle  = 0;
                rx_idle  = 0;
                hold_req = 1'b1;
            end
            // idle the sender before this item
            if (tx_idle > 0 && $urandom_range(0, 99) < tx_idle) begin
                src.valid <= 1'b0;
                @(posedge i_clk);
                while ($urandom_range(0, 99) < tx_idle) @(posedge i_clk);
            end
            src.valid         <= 1'b1;
            src.source_byte   <= text_items[i][7:0];
            src.end_of_source <= text_items[i][8];
            @(posedge i_clk);
            while (!src.ready) @(posedge i_clk);
            sent++;
        end
        src.valid <= 1'b0;
        drain = 0;
        while (pending != 0 && drain < 5000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (20) @(posedge i_clk);
        $display("Sent %0d source items incl. end of text; checked %0d tokens.", sent,
                 checked);
        $display("Idling phases, one long output hold-off and post-EOF items covered.");
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
`default_nettype wire
